### rtl/salru_pkg.sv
// salru_pkg: shared types and constants of the set-associative lru tag store
// used by every module of the block but salru_ram; no dependencies
`default_nettype none

package salru_pkg;

  // fixed field widths
  localparam int ADDR_W  = 24;  // width of the address field
  localparam int CFG_W   = 4;   // width of each configuration register
  localparam int IDX_W   = 15;  // widest set index the split can give
  localparam int PADDR_W = 4;   // byte address of the register port
  localparam int PDATA_W = 32;  // data width of the register port

  // access kinds
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_STORE = 1'b1;

  // register indexes, taken from paddr word bits
  localparam logic [1:0] REG_OFFSET_WIDTH = 2'd0;
  localparam logic [1:0] REG_INDEX_WIDTH  = 2'd1;
  localparam logic [1:0] REG_WAYS_IN_USE  = 2'd2;

  // register values after reset
  localparam logic [CFG_W-1:0] RST_OFFSET_WIDTH = 4'd5;
  localparam logic [CFG_W-1:0] RST_INDEX_WIDTH  = 4'd5;
  localparam logic [CFG_W-1:0] RST_WAYS_IN_USE  = 4'd4;

  // configuration seen by the datapath
  typedef struct packed {
    logic [CFG_W-1:0] offset_width;
    logic [CFG_W-1:0] index_width;
    logic [CFG_W-1:0] ways_in_use;
  } cfg_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic clr_wr;   // write one cleared row of the sweep
    logic cap;      // capture an input beat
    logic split;    // split address, start set reduction
    logic rd_sel;   // finish set reduction, read the row
    logic update;   // compare, write back, load the result
  } dp_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic clr_last;  // sweep is at its last row
    logic out_free;  // result register can take a new beat
  } dp_sts_t;

endpackage

`default_nettype wire

### rtl/set_assoc_lru_tag_store.sv
// set_assoc_lru_tag_store: top level, register port, controller and datapath
// depends on salru_pkg, salru_regs, salru_ctrl, salru_dp, salru_ram
`default_nettype none

// Tag store of a set-associative cache with true lru order per set (way 0
// most recent). Each input beat is a load or store address, each output beat
// one hit flag. After reset the block runs a clearing pass over all SETS rows
// (1024 at the default), writing one row of the set ram per cycle, with
// in_ready low; register writes are taken throughout. After that an access
// runs through three steps: address split with the reciprocal step of the set
// reduction, remainder and row read, then compare and write back of the
// reordered row. The next beat is taken in the write-back cycle, so a new
// access starts only once the previous one reaches the write back of the
// single row ram. A result not yet taken stalls the write-back cycle until
// the output register frees up.
module set_assoc_lru_tag_store #(
  parameter int ADDR_BITS = 24,
  parameter int WAYS      = 8,
  parameter int SETS      = 1024
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // input channel
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           in_cmd,
  input  wire logic [salru_pkg::ADDR_W-1:0]   in_address,
  // result channel
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_hit,
  // register port
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [salru_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [salru_pkg::PDATA_W-1:0]  pwdata,
  output logic      [salru_pkg::PDATA_W-1:0]  prdata,
  output logic                                pready
);

  salru_pkg::cfg_t    cfg;
  salru_pkg::dp_cmd_t dp_cmd;
  salru_pkg::dp_sts_t dp_sts;

  // configuration registers
  salru_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequence control
  salru_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (dp_cmd),
    .sts      (dp_sts)
  );

  // tag datapath
  salru_dp #(
    .ADDR_BITS (ADDR_BITS),
    .WAYS      (WAYS),
    .SETS      (SETS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (dp_cmd),
    .sts        (dp_sts),
    .cfg        (cfg),
    .in_cmd     (in_cmd),
    .in_address (in_address),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_hit    (out_hit)
  );

endmodule

`default_nettype wire

### rtl/salru_ram.sv
// salru_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
`default_nettype none

module salru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

### rtl/salru_regs.sv
// salru_regs: configuration registers behind the apb-style port
// depends on salru_pkg
`default_nettype none

module salru_regs (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [salru_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [salru_pkg::PDATA_W-1:0]   pwdata,
  output logic      [salru_pkg::PDATA_W-1:0]   prdata,
  output logic                                 pready,
  output salru_pkg::cfg_t                      cfg
);

  salru_pkg::cfg_t cfg_r;
  salru_pkg::cfg_t cfg_nxt;
  logic            wr_en;
  logic [1:0]      reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[3:2];
  assign cfg     = cfg_r;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_sel)
        salru_pkg::REG_OFFSET_WIDTH: cfg_nxt.offset_width = pwdata[salru_pkg::CFG_W-1:0];
        salru_pkg::REG_INDEX_WIDTH:  cfg_nxt.index_width  = pwdata[salru_pkg::CFG_W-1:0];
        salru_pkg::REG_WAYS_IN_USE:  cfg_nxt.ways_in_use  = pwdata[salru_pkg::CFG_W-1:0];
        default:                     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.offset_width <= salru_pkg::RST_OFFSET_WIDTH;
      cfg_r.index_width  <= salru_pkg::RST_INDEX_WIDTH;
      cfg_r.ways_in_use  <= salru_pkg::RST_WAYS_IN_USE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // read mux
  always_comb begin
    unique case (reg_sel)
      salru_pkg::REG_OFFSET_WIDTH:
        prdata = salru_pkg::PDATA_W'(cfg_r.offset_width);
      salru_pkg::REG_INDEX_WIDTH:
        prdata = salru_pkg::PDATA_W'(cfg_r.index_width);
      salru_pkg::REG_WAYS_IN_USE:
        prdata = salru_pkg::PDATA_W'(cfg_r.ways_in_use);
      default:
        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/salru_dp.sv
// salru_dp: datapath of the tag store: address split, set reduction,
// row ram, tag compare and lru reorder, result register
// depends on salru_pkg and salru_ram
`default_nettype none

module salru_dp #(
  parameter int ADDR_BITS = 24,
  parameter int WAYS      = 8,
  parameter int SETS      = 1024
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire salru_pkg::dp_cmd_t             cmd,
  output salru_pkg::dp_sts_t                  sts,
  input  wire salru_pkg::cfg_t                cfg,
  input  wire logic                           in_cmd,
  input  wire logic [salru_pkg::ADDR_W-1:0]   in_address,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_hit
);

  localparam int IDX_W   = salru_pkg::IDX_W;
  localparam int AW      = (ADDR_BITS < salru_pkg::ADDR_W) ? ADDR_BITS : salru_pkg::ADDR_W;
  localparam int ENT_W   = AW + 1;
  localparam int ROW_W   = WAYS * ENT_W;
  localparam int SET_LOG = $clog2(SETS);
  localparam int SET_W   = (SETS > 1) ? SET_LOG : 1;
  localparam int SH      = IDX_W + SET_LOG;
  localparam int M_W     = IDX_W + 2;
  localparam int PROD_W  = IDX_W + M_W;
  localparam int WAY_W   = $clog2(WAYS + 1);
  localparam int POS_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  // reciprocal of the set count, exact floor for any index below 2^IDX_W
  localparam logic [M_W-1:0] RECIP =
    M_W'(((longint'(1) << SH) + longint'(SETS) - longint'(1)) / longint'(SETS));
  localparam logic [IDX_W-1:0] SETS_C  = IDX_W'(SETS);
  localparam logic [SET_W-1:0] LAST_SET = SET_W'(SETS - 1);

  // captured beat
  logic             cmd_r;
  logic [AW-1:0]    addr_r;
  // split results
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] quot_r;
  logic [AW-1:0]    tag_r;
  logic [SET_W-1:0] set_r;
  // clearing sweep
  logic [SET_W-1:0] clr_cnt_r;
  logic [SET_W-1:0] clr_cnt_nxt;
  // result register
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             out_hit_r;

  // capture input beat, address taken modulo 2^ADDR_BITS
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      cmd_r  <= in_cmd;
      addr_r <= in_address[AW-1:0];
    end
  end

  // address split and reciprocal step of the set reduction
  logic [AW-1:0]       addr_shift;
  logic [AW+IDX_W-1:0] shift_ext;
  logic [IDX_W-1:0]    idx_mask;
  logic [IDX_W-1:0]    idx_comb;
  logic [4:0]          tag_shamt;
  logic [AW-1:0]       tag_comb;
  logic [PROD_W-1:0]   prod;
  logic [PROD_W-1:0]   quot;

  always_comb begin
    addr_shift = addr_r >> cfg.offset_width;
    shift_ext  = {{IDX_W{1'b0}}, addr_shift};
    idx_mask   = ~({IDX_W{1'b1}} << cfg.index_width);
    idx_comb   = shift_ext[IDX_W-1:0] & idx_mask;
    tag_shamt  = {1'b0, cfg.offset_width} + {1'b0, cfg.index_width};
    tag_comb   = addr_r >> tag_shamt;
    prod       = PROD_W'(idx_comb) * PROD_W'(RECIP);
    quot       = prod >> SH;
  end

  always_ff @(posedge clk) begin
    if (cmd.split) begin
      idx_r  <= idx_comb;
      tag_r  <= tag_comb;
      quot_r <= quot[IDX_W-1:0];
    end
  end

  // remainder gives the set
  logic [IDX_W-1:0] quot_sets;
  logic [IDX_W-1:0] rem;
  logic [SET_W-1:0] set_comb;

  always_comb begin
    quot_sets = IDX_W'(quot_r * SETS_C);
    rem       = idx_r - quot_sets;
    set_comb  = rem[SET_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_sel) begin
      set_r <= set_comb;
    end
  end

  // row ram, one row per set, way 0 most recent
  logic             ram_we;
  logic [SET_W-1:0] ram_waddr;
  logic [ROW_W-1:0] ram_wdata;
  logic [SET_W-1:0] ram_raddr;
  logic [ROW_W-1:0] ram_rdata;
  logic [ROW_W-1:0] row_new;
  logic             row_wr;

  assign ram_raddr = cmd.rd_sel ? set_comb : set_r;
  assign ram_we    = cmd.clr_wr | (cmd.update & row_wr);
  assign ram_waddr = cmd.clr_wr ? clr_cnt_r : set_r;
  assign ram_wdata = cmd.clr_wr ? '0 : row_new;

  salru_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_row_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ways in use, clamped to 1..WAYS
  logic [WAY_W-1:0] n_eff;

  always_comb begin
    if (cfg.ways_in_use == '0) begin
      n_eff = WAY_W'(1);
    end else if (int'(cfg.ways_in_use) > WAYS) begin
      n_eff = WAY_W'(WAYS);
    end else begin
      n_eff = WAY_W'(cfg.ways_in_use);
    end
  end

  // tag compare over used ways, first match wins
  logic [ENT_W-1:0] ent   [WAYS];
  logic [WAYS-1:0]  match;
  logic             hit;
  logic [POS_W-1:0] pos;

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      ent[i]   = ram_rdata[i*ENT_W +: ENT_W];
      match[i] = ent[i][ENT_W-1] && (ent[i][AW-1:0] == tag_r) && (i < int'(n_eff));
    end
    hit = |match;
    pos = POS_W'(n_eff - WAY_W'(1));
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (match[i]) begin
        pos = POS_W'(i);
      end
    end
  end

  // bring to front: way 0 takes the tag, ways up to pos shift back
  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      if (i == 0) begin
        row_new[i*ENT_W +: ENT_W] = {1'b1, tag_r};
      end else if (i <= int'(pos)) begin
        row_new[i*ENT_W +: ENT_W] = ent[i-1];
      end else begin
        row_new[i*ENT_W +: ENT_W] = ent[i];
      end
    end
    row_wr = hit | (cmd_r == salru_pkg::CMD_LOAD);
  end

  // clearing sweep counter
  always_comb begin
    clr_cnt_nxt = clr_cnt_r;
    if (cmd.clr_wr) begin
      clr_cnt_nxt = clr_cnt_r + SET_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else begin
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.update) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_hit_r <= hit;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_hit      = out_hit_r;
  assign sts.clr_last = (clr_cnt_r == LAST_SET);
  assign sts.out_free = ~out_valid_r | out_ready;

endmodule

`default_nettype wire

### rtl/salru_ctrl.sv
// salru_ctrl: controller of the tag store: clearing sweep and access sequence
// depends on salru_pkg
`default_nettype none

module salru_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output salru_pkg::dp_cmd_t      cmd,
  input  wire salru_pkg::dp_sts_t sts
);

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_SPLIT  = 5'b00100,
    ST_READ   = 5'b01000,
    ST_UPDATE = 5'b10000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // next state and datapath commands
  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = ST_SPLIT;
        end
      end
      ST_SPLIT: begin
        cmd.split = 1'b1;
        state_nxt = ST_READ;
      end
      ST_READ: begin
        cmd.rd_sel = 1'b1;
        state_nxt  = ST_UPDATE;
      end
      ST_UPDATE: begin
        // wait here while the previous result is not taken
        if (sts.out_free) begin
          cmd.update = 1'b1;
          in_ready   = 1'b1;
          if (in_valid) begin
            cmd.cap   = 1'b1;
            state_nxt = ST_SPLIT;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire
